>>> hw/rtl/script_push_tokenizer_core_defines.svh
// Assertion macros for the script push tokenizer.
// Expects clk and arst_n in the scope of use.
`ifndef SCRIPT_PUSH_TOKENIZER_CORE_DEFINES_SVH
`define SCRIPT_PUSH_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/spt_pkg.sv
// Package for the script push tokenizer: transfer types, codes, helpers.
// No dependencies.
`default_nettype none

package spt_pkg;

	localparam logic [7:0] PUSH_DIRECT_LOW  = 8'h01;
	localparam logic [7:0] PUSH_DIRECT_HIGH = 8'h4b;
	localparam logic [7:0] OPC_PUSHDATA1    = 8'h4c;
	localparam logic [7:0] OPC_PUSHDATA2    = 8'h4d;
	localparam logic [7:0] OPC_PUSHDATA4    = 8'h4e;
	localparam logic [7:0] LAST_NAMED_OP    = 8'hba;
	localparam logic [7:0] OPC_INVALID      = 8'hff;

	localparam logic [1:0] PH_OPCODE = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;

	localparam logic [1:0] ROLE_PLAIN  = 2'd0;
	localparam logic [1:0] ROLE_PUSH   = 2'd1;
	localparam logic [1:0] ROLE_LENGTH = 2'd2;
	localparam logic [1:0] ROLE_DATA   = 2'd3;

	typedef struct packed {
		logic [7:0] script_byte;
		logic       last_byte;
	} spt_in_t;

	typedef struct packed {
		logic [1:0]  role;
		logic [7:0]  token_opcode;
		logic        known_name;
		logic [31:0] push_length;
		logic [31:0] data_position;
		logic        token_end;
		logic        truncated;
	} spt_out_t;

	function automatic logic [2:0] len_size(input logic [7:0] op);
		logic [2:0] r;
		case (op)
			OPC_PUSHDATA1: r = 3'd1;
			OPC_PUSHDATA2: r = 3'd2;
			default:       r = 3'd4;
		endcase
		return r;
	endfunction

	function automatic logic is_named(input logic [7:0] op);
		return (op <= LAST_NAMED_OP) || (op == OPC_INVALID);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/script_push_tokenizer_core.sv
// Script push tokenizer top level: one tag per script byte.
// Depends on spt_pkg and script_push_tokenizer_core_defines.svh.
//
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item) takes one script byte per
//   transfer, last_byte set on the final byte of a script.
//   tag channel (tag_valid/tag_ready/tag_item) gives one tag per byte, in order.
// Path: an accepted byte is loaded into the input register, then tagged by the
//   parse logic and loaded into the result register, which presents its tag on
//   the tag channel.
// Throughput: 1 byte per cycle while tag_ready stays high; the parse state
//   (phase, opcode, length and data counters) updates between the two registers.
// Stall: while tag_ready is low the result register holds; the input register
//   takes one more byte, then byte_ready drops until the tag is taken.
// Reset: arst_n clears both valid flags and returns the parser to expecting
//   an opcode with all counters zero.
// A byte with last_byte set also returns the parser to expecting an opcode.
`default_nettype none

module script_push_tokenizer_core (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             byte_valid,
	output logic            byte_ready,
	input  wire spt_pkg::spt_in_t byte_item,
	output logic            tag_valid,
	input  wire             tag_ready,
	output spt_pkg::spt_out_t tag_item
);
	import spt_pkg::*;
	`include "script_push_tokenizer_core_defines.svh"

	spt_in_t     item_s1;
	logic        valid_s1;
	spt_out_t    tag_q;
	logic        tag_valid_q;
	logic        adv;

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  op_q, op_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  llft_q, llft_d;
	logic [31:0] dleft_q, dleft_d;
	logic [31:0] didx_q, didx_d;

	logic [7:0]  b;
	logic        last;
	logic [2:0]  total;
	logic [1:0]  pos;
	logic [31:0] shifted;
	spt_out_t    res;

	assign adv        = valid_s1 && (!tag_valid_q || tag_ready);
	assign byte_ready = !valid_s1 || adv;
	assign tag_valid  = tag_valid_q;
	assign tag_item   = tag_q;

	assign b       = item_s1.script_byte;
	assign last    = item_s1.last_byte;
	assign total   = len_size(op_q);
	assign pos     = 2'(total - llft_q);
	assign shifted = {24'd0, b} << {pos, 3'b000};

	always_comb begin
		phase_d = phase_q;
		op_d    = op_q;
		acc_d   = acc_q;
		llft_d  = llft_q;
		dleft_d = dleft_q;
		didx_d  = didx_q;
		res     = '0;
		case (phase_q)
			PH_LENGTH: begin
				acc_d           = acc_q | shifted;
				llft_d          = llft_q - 3'd1;
				res.role        = ROLE_LENGTH;
				res.push_length = acc_d;
				if (llft_d == 3'd0) begin
					if (acc_d == 32'd0) begin
						res.token_end = 1'b1;
						phase_d       = PH_OPCODE;
					end else begin
						res.token_end = last;
						res.truncated = last;
						phase_d       = PH_DATA;
						dleft_d       = acc_d;
						didx_d        = 32'd0;
					end
				end else begin
					res.token_end = last;
					res.truncated = last;
				end
			end
			PH_DATA: begin
				res.role          = ROLE_DATA;
				res.push_length   = (op_q <= PUSH_DIRECT_HIGH) ? {24'd0, op_q} : acc_q;
				res.data_position = didx_q;
				didx_d            = didx_q + 32'd1;
				dleft_d           = dleft_q - 32'd1;
				if (dleft_d == 32'd0) begin
					res.token_end = 1'b1;
					phase_d       = PH_OPCODE;
				end else begin
					res.token_end = last;
					res.truncated = last;
				end
			end
			default: begin
				op_d = b;
				if (b >= PUSH_DIRECT_LOW && b <= PUSH_DIRECT_HIGH) begin
					res.role        = ROLE_PUSH;
					res.push_length = {24'd0, b};
					phase_d         = PH_DATA;
					dleft_d         = {24'd0, b};
					didx_d          = 32'd0;
					res.token_end   = last;
					res.truncated   = last;
				end else if (b == OPC_PUSHDATA1 || b == OPC_PUSHDATA2
						|| b == OPC_PUSHDATA4) begin
					res.role      = ROLE_PUSH;
					phase_d       = PH_LENGTH;
					acc_d         = 32'd0;
					llft_d        = len_size(b);
					res.token_end = last;
					res.truncated = last;
				end else begin
					res.role      = ROLE_PLAIN;
					phase_d       = PH_OPCODE;
					res.token_end = 1'b1;
				end
			end
		endcase
		res.token_opcode = op_d;
		res.known_name   = is_named(op_d);
		if (last) begin
			phase_d = PH_OPCODE;
			llft_d  = 3'd0;
			dleft_d = 32'd0;
			didx_d  = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			tag_valid_q <= 1'b0;
			phase_q     <= PH_OPCODE;
			op_q        <= 8'd0;
			acc_q       <= 32'd0;
			llft_q      <= 3'd0;
			dleft_q     <= 32'd0;
			didx_q      <= 32'd0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (adv) begin
				tag_valid_q <= 1'b1;
				phase_q     <= phase_d;
				op_q        <= op_d;
				acc_q       <= acc_d;
				llft_q      <= llft_d;
				dleft_q     <= dleft_d;
				didx_q      <= didx_d;
			end else if (tag_ready) begin
				tag_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			item_s1 <= byte_item;
		end
		if (adv) begin
			tag_q <= res;
		end
	end

	`SPT_ASSERT_NOW(a_ready_only_on_full, !byte_ready, valid_s1 && tag_valid_q && !tag_ready, "byte_ready low without a full stall")
	`SPT_ASSERT_NOW(a_trunc_ends, tag_valid && tag_item.truncated, tag_item.token_end, "truncated tag without token end")
	`SPT_ASSERT_NOW(a_plain_closed, tag_valid && tag_item.role == ROLE_PLAIN, tag_item.token_end && !tag_item.truncated, "plain opcode tag not a closed token")
	`SPT_ASSERT_NEXT(a_len_count, adv && phase_d == PH_LENGTH, llft_q != 3'd0, "length phase with no length bytes left")

endmodule

`default_nettype wire
